>>> sv/rmpi_pkg.sv
// ----------------------------------------------------------------------------
// rmpi_pkg
// Shared types and constants of the recursive mutex with priority inheritance.
// ----------------------------------------------------------------------------
package rmpi_pkg;

  localparam int MAX_WAITERS = 16;
  localparam int MAX_TASKS   = 64;

  localparam int TID_W  = 6;
  localparam int PRIO_W = 8;
  localparam int HOLD_W = 16;
  localparam int STAT_W = 3;
  localparam int OP_W   = 2;

  // waiter count holds 0..MAX_WAITERS, stack index 0..MAX_WAITERS-1
  localparam int WCNT_W = $clog2(MAX_WAITERS + 1);
  localparam int WIDX_W = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;

  localparam logic [OP_W-1:0] OP_LOCK    = 2'd0;
  localparam logic [OP_W-1:0] OP_TRYLOCK = 2'd1;
  localparam logic [OP_W-1:0] OP_UNLOCK  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
  localparam logic [STAT_W-1:0] STAT_WOULD_BLK  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_QUEUED     = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_OWNER  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_WAIT_OVF   = 3'd4;
  localparam logic [STAT_W-1:0] STAT_COUNT_OVF  = 3'd5;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TID_W-1:0]  tid;
    logic [PRIO_W-1:0] prio;
  } req_t;

  typedef struct packed {
    logic              held;
    logic [TID_W-1:0]  owner;
    logic [HOLD_W-1:0] depth;
    logic [PRIO_W-1:0] acq_prio;
    logic [PRIO_W-1:0] own_prio;
    logic [WCNT_W-1:0] wcnt;
  } holder_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              woken_valid;
    logic [TID_W-1:0]  woken_task;
    logic              raise_valid;
    logic [PRIO_W-1:0] raise_prio;
    logic              restore_valid;
    logic [PRIO_W-1:0] restore_prio;
    logic              owner_valid;
    logic [TID_W-1:0]  owner;
    logic [HOLD_W-1:0] hold_count;
  } res_t;

  typedef struct packed {
    logic              en;
    logic [WIDX_W-1:0] idx;
    logic [TID_W-1:0]  tid;
  } push_t;

endpackage

>>> sv/rmpi_ram.sv
// ----------------------------------------------------------------------------
// rmpi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rmpi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/rmpi_core.sv
// ----------------------------------------------------------------------------
// rmpi_core
// Request decision logic: next holder record, stack push and result word.
// ----------------------------------------------------------------------------
module rmpi_core import rmpi_pkg::*; (
  input  req_t             req_i,
  input  holder_t          cur_i,
  input  logic [TID_W-1:0] top_tid_i,
  output holder_t          nxt_o,
  output push_t            push_o,
  output res_t             res_o
);

  logic tid_bad;

  assign tid_bad = (32'(req_i.tid) >= MAX_TASKS);

  always_comb begin
    nxt_o        = cur_i;
    res_o        = '0;
    push_o.en    = 1'b0;
    push_o.idx   = cur_i.wcnt[WIDX_W-1:0];
    push_o.tid   = req_i.tid;
    res_o.status = STAT_OK;

    if (tid_bad) begin
      res_o.status = STAT_NOT_OWNER;
    end else begin
      case (req_i.op)
        OP_UNLOCK: begin
          if (!cur_i.held || cur_i.owner != req_i.tid) begin
            res_o.status = STAT_NOT_OWNER;
          end else begin
            nxt_o.depth = cur_i.depth - HOLD_W'(1);
            if (nxt_o.depth == '0) begin
              res_o.restore_valid = 1'b1;
              res_o.restore_prio  = cur_i.acq_prio;
              nxt_o.held          = 1'b0;
              nxt_o.owner         = '0;
              nxt_o.own_prio      = '0;
              if (cur_i.wcnt != '0) begin
                nxt_o.wcnt        = cur_i.wcnt - WCNT_W'(1);
                res_o.woken_valid = 1'b1;
                res_o.woken_task  = top_tid_i;
              end
            end
          end
        end
        OP_LOCK, OP_TRYLOCK: begin
          if (!cur_i.held) begin
            nxt_o.held     = 1'b1;
            nxt_o.owner    = req_i.tid;
            nxt_o.depth    = HOLD_W'(1);
            nxt_o.acq_prio = req_i.prio;
            nxt_o.own_prio = req_i.prio;
          end else if (cur_i.owner == req_i.tid) begin
            if (cur_i.depth == '1) begin
              res_o.status = STAT_COUNT_OVF;
            end else begin
              nxt_o.depth = cur_i.depth + HOLD_W'(1);
            end
          end else if (req_i.op == OP_TRYLOCK) begin
            res_o.status = STAT_WOULD_BLK;
          end else begin
            if (req_i.prio > cur_i.own_prio) begin
              nxt_o.own_prio    = req_i.prio;
              res_o.raise_valid = 1'b1;
              res_o.raise_prio  = req_i.prio;
            end
            if (cur_i.wcnt >= WCNT_W'(MAX_WAITERS)) begin
              res_o.status = STAT_WAIT_OVF;
            end else begin
              push_o.en    = 1'b1;
              nxt_o.wcnt   = cur_i.wcnt + WCNT_W'(1);
              res_o.status = STAT_QUEUED;
            end
          end
        end
        default: begin
          res_o.status = STAT_NOT_OWNER;
        end
      endcase
    end

    // visible holder state after this request
    res_o.owner_valid = nxt_o.held;
    res_o.owner       = nxt_o.held ? nxt_o.owner : '0;
    res_o.hold_count  = nxt_o.held ? nxt_o.depth : '0;
  end

endmodule

>>> sv/recursive_mutex_priority_inherit.sv
// ----------------------------------------------------------------------------
// recursive_mutex_priority_inherit
// Single-lock recursive hardware mutex with priority inheritance.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive operation_i / task_id_i / task_priority_i and raise
//   start. The word is taken at the rising edge where start is high and busy
//   is low; busy then stays high for one cycle while the request executes.
//   Result channel: done_o pulses for one cycle with the result word on the
//   status and owner/priority ports. The result cannot be stalled; the
//   receiver must take it in that cycle.
//   Timing: the request word is registered on accept, decided in the EXEC
//   state, and the result word and done_o are registered at the end of
//   EXEC. No new request is taken while busy; the block returns to idle
//   between requests so that the waiter stack RAM (registered read) can
//   supply the top waiter for an unlock that wakes someone.
//   Reset: lock free, hold count zero, waiter stack empty. The stack RAM
//   contents are not cleared; only entries below the waiter count are used.
//   Holder record lives in flops; waiters in a MAX_WAITERS x 6 RAM.
// ----------------------------------------------------------------------------
module recursive_mutex_priority_inherit import rmpi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [TID_W-1:0]  task_id_i,
  input  logic [PRIO_W-1:0] task_priority_i,
  output logic              done_o,
  output logic [STAT_W-1:0] status_o,
  output logic              woken_valid_o,
  output logic [TID_W-1:0]  woken_task_o,
  output logic              raise_valid_o,
  output logic [PRIO_W-1:0] raise_priority_o,
  output logic              restore_valid_o,
  output logic [PRIO_W-1:0] restore_priority_o,
  output logic              cur_owner_valid_o,
  output logic [TID_W-1:0]  cur_owner_o,
  output logic [HOLD_W-1:0] cur_hold_count_o
);

  state_e  state_q, state_d;
  req_t    req_q;
  holder_t holder_q, holder_d;
  res_t    res_q, res_d;
  push_t   push;
  logic    done_q;

  logic              accept;
  logic              exec_en;
  logic [WCNT_W-1:0] top_ptr;
  logic [TID_W-1:0]  top_tid;

  // top of stack is read every cycle; wcnt only moves at the end of EXEC,
  // so the data seen in EXEC matches the current count
  assign top_ptr = holder_q.wcnt - WCNT_W'(1);

  rmpi_ram #(
    .WIDTH (TID_W),
    .DEPTH (MAX_WAITERS)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (push.en & exec_en),
    .waddr_i (push.idx),
    .wdata_i (push.tid),
    .raddr_i (top_ptr[WIDX_W-1:0]),
    .rdata_o (top_tid)
  );

  rmpi_core u_core (
    .req_i     (req_q),
    .cur_i     (holder_q),
    .top_tid_i (top_tid),
    .nxt_o     (holder_d),
    .push_o    (push),
    .res_o     (res_d)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    busy    = 1'b0;
    exec_en = 1'b0;
    case (state_q)
      S_IDLE: begin
        busy    = 1'b0;
        exec_en = 1'b0;
      end
      S_EXEC: begin
        busy    = 1'b1;
        exec_en = 1'b1;
      end
      default: begin
        busy    = 1'b1;
        exec_en = 1'b0;
      end
    endcase
  end

  assign accept = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      holder_q <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= exec_en;
      if (exec_en) begin
        holder_q <= holder_d;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.op   <= operation_i;
      req_q.tid  <= task_id_i;
      req_q.prio <= task_priority_i;
    end
    if (exec_en) begin
      res_q <= res_d;
    end
  end

  assign done_o             = done_q;
  assign status_o           = res_q.status;
  assign woken_valid_o      = res_q.woken_valid;
  assign woken_task_o       = res_q.woken_task;
  assign raise_valid_o      = res_q.raise_valid;
  assign raise_priority_o   = res_q.raise_prio;
  assign restore_valid_o    = res_q.restore_valid;
  assign restore_priority_o = res_q.restore_prio;
  assign cur_owner_valid_o  = res_q.owner_valid;
  assign cur_owner_o        = res_q.owner;
  assign cur_hold_count_o   = res_q.hold_count;

  // ------------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------------
  // every result strobe follows exactly one execute cycle
  a_done_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_EXEC))
    else $error("result strobe without execute cycle");

  // waiter count never exceeds the stack depth
  a_wcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    holder_q.wcnt <= WCNT_W'(MAX_WAITERS))
    else $error("waiter count past stack depth");

  // a free lock has no owner and no hold count
  a_free_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !holder_q.held |-> (holder_q.depth == '0 && holder_q.owner == '0))
    else $error("free lock carries holder data");

  // a wake only happens on the final unlock, leaving the lock free
  a_wake_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && woken_valid_o) |-> (restore_valid_o && !cur_owner_valid_o))
    else $error("waiter woken without lock release");

endmodule
